// File: design/bcpa_pkg.sv
package bcpa_pkg;

    localparam int WORD_BITS   = 64;
    localparam int WORD_SHIFT  = 6;
    localparam int CHUNK_BITS  = 8;
    localparam int CHUNK_SHIFT = 3;
    localparam int SIZE_W      = 26;
    localparam int ADDR_W      = 25;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 32;

    typedef enum logic [7:0] {
        ST_INIT  = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_RD    = 8'b0000_0100,
        ST_LATCH = 8'b0000_1000,
        ST_CHUNK = 8'b0001_0000,
        ST_MRD   = 8'b0010_0000,
        ST_MWR   = 8'b0100_0000,
        ST_RESP  = 8'b1000_0000
    } t_state;

endpackage

// File: design/bcpa_ram.sv
module bcpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/bitmap_contiguous_page_allocator.sv
// First-fit contiguous page allocator over a one-bit-per-page used map.
// Slave stream: one request per transaction; tuser = region (1 = low reserved
// pages, 0 = general pages above them), tdata = size in bytes. Master stream:
// one response per request; tuser = granted, tdata = byte address of the first
// granted page (0 on failure). Sizes round up to whole pages; a zero-page
// request reports the first free page of the region and marks nothing.
// The map lives in a 64-bit wide RAM with a registered read port. After reset
// a clearing pass writes the initial map, one word per cycle, over
// ceil(TOTAL_PAGE_COUNT/64) words (128 at the defaults); requests are held
// off meanwhile. After a request is accepted, the search reads one map word
// per step while words are wholly free or wholly used, scans a partly used
// word in 8 byte-wide steps and then reads the next word, and marking reads
// and writes back each map word of the granted run.
// One request is in flight at a time. The response sits in an output
// register, so a new request is taken while an earlier response waits; a
// finished search holds until that register frees up when the receiver
// stalls.
module bitmap_contiguous_page_allocator
    import bcpa_pkg::*;
#(
    parameter int TOTAL_PAGE_COUNT   = 8192,
    parameter int PAGE_BYTES         = 4096,
    parameter int LOW_RESERVED_PAGES = 2560
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [25:0] size_bytes, rest zero
    input  logic                  i_s_tuser,   // [0] region
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [24:0] start_address, rest zero
    output logic                  o_m_tuser    // [0] granted
);

    // PAGE_BYTES is a power of two
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int MAP_WORDS  = (TOTAL_PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PA_W       = AW + WORD_SHIFT;
    localparam int PG_W       = SIZE_W + 1 - PAGE_SHIFT;
    localparam int CNT_W      = (PG_W > PA_W + 1) ? PG_W : PA_W + 1;
    localparam int AF_W       = PA_W + PAGE_SHIFT + ADDR_W;
    localparam int LIM        = (LOW_RESERVED_PAGES < TOTAL_PAGE_COUNT) ?
                                LOW_RESERVED_PAGES : TOTAL_PAGE_COUNT;

    localparam logic [PA_W-1:0] R0_LO    = PA_W'(LIM);
    localparam logic [PA_W-1:0] R0_HM    = PA_W'(TOTAL_PAGE_COUNT - 1);
    localparam logic [PA_W-1:0] R1_LO    = '0;
    localparam logic [PA_W-1:0] R1_HM    = PA_W'(LIM - 1);
    localparam logic            R0_EMPTY = (LIM == TOTAL_PAGE_COUNT);
    localparam logic            R1_EMPTY = (LIM == 0);
    localparam logic [PA_W:0]   LIM_X    = (PA_W + 1)'(LIM);
    localparam logic [AW-1:0]   LAST_W   = AW'(MAP_WORDS - 1);
    localparam logic [WORD_BITS-1:0] ONES = '1;

    t_state                r_state, n_state;
    logic                  r_region, n_region;
    logic [PG_W-1:0]       r_pages, n_pages;
    logic [CNT_W-1:0]      r_run, n_run;
    logic [PA_W-1:0]       r_cand, n_cand;
    logic [AW-1:0]         r_widx, n_widx;
    logic [CHUNK_SHIFT-1:0] r_chunk, n_chunk;
    logic [WORD_BITS-1:0]  r_word, n_word;
    logic [PA_W-1:0]       r_start, n_start;
    logic [PA_W-1:0]       r_mlast, n_mlast;
    logic                  r_found, n_found;
    logic                  r_ovalid, n_ovalid;
    logic                  r_ogrant, n_ogrant;
    logic [ADDR_W-1:0]     r_oaddr, n_oaddr;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;

    bcpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // region bounds
    logic                  sel_region;
    logic [PA_W-1:0]       reg_lo, reg_hm;
    logic                  reg_empty;
    logic [AW-1:0]         lo_w, hm_w;
    logic                  word_last;
    logic [WORD_BITS-1:0]  keep, eff_word;
    logic                  all_used, all_free;
    logic [PA_W-1:0]       base_pg, cand_eff;
    logic                  fits, pages_zero;
    logic [SIZE_W:0]       size_up;
    logic                  s_acc;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign sel_region = (r_state == ST_IDLE) ? i_s_tuser : r_region;
    assign reg_lo     = sel_region ? R1_LO : R0_LO;
    assign reg_hm     = sel_region ? R1_HM : R0_HM;
    assign reg_empty  = sel_region ? R1_EMPTY : R0_EMPTY;
    assign lo_w       = reg_lo[PA_W-1:WORD_SHIFT];
    assign hm_w       = reg_hm[PA_W-1:WORD_SHIFT];
    assign word_last  = (r_widx == hm_w);
    assign base_pg    = {r_widx, {WORD_SHIFT{1'b0}}};
    assign pages_zero = (r_pages == '0);
    assign size_up    = {1'b0, i_s_tdata[SIZE_W-1:0]} + (SIZE_W + 1)'(PAGE_BYTES - 1);

    // pages outside the region count as used
    always_comb begin
        keep = ONES;
        if (r_widx == lo_w) begin
            keep = keep & (ONES << reg_lo[WORD_SHIFT-1:0]);
        end
        if (r_widx == hm_w) begin
            keep = keep & (ONES >> (WORD_SHIFT'(WORD_BITS - 1) - reg_hm[WORD_SHIFT-1:0]));
        end
    end

    assign eff_word = ram_rdata | ~keep;
    assign all_used = &eff_word;
    assign all_free = ~|eff_word;
    assign cand_eff = (r_run == '0) ? base_pg : r_cand;
    assign fits     = ({1'b0, r_run} + (CNT_W + 1)'(WORD_BITS)) >=
                      {1'b0, CNT_W'(r_pages)};

    // chunk scan of a partly used word, one byte-wide chunk per step
    logic [CHUNK_BITS-1:0] cbits;
    logic [CNT_W-1:0]      cs_run;
    logic [PA_W-1:0]       cs_cand, cs_start;
    logic                  cs_hit;

    always_comb begin
        cbits    = r_word[r_chunk * CHUNK_BITS +: CHUNK_BITS];
        cs_run   = r_run;
        cs_cand  = r_cand;
        cs_hit   = 1'b0;
        cs_start = r_cand;
        for (int b = 0; b < CHUNK_BITS; b++) begin
            if (!cs_hit) begin
                if (cbits[b]) begin
                    cs_run = '0;
                end else begin
                    if (cs_run == '0) begin
                        cs_cand = {r_widx, r_chunk, CHUNK_SHIFT'(b)};
                    end
                    if (pages_zero) begin
                        cs_hit   = 1'b1;
                        cs_start = cs_cand;
                    end else begin
                        cs_run = cs_run + 1'b1;
                        if (cs_run == CNT_W'(r_pages)) begin
                            cs_hit   = 1'b1;
                            cs_start = cs_cand;
                        end
                    end
                end
            end
        end
    end

    // clearing pass pattern
    logic [PA_W:0]         init_base;
    logic [WORD_BITS-1:0]  init_word;

    assign init_base = {1'b0, base_pg};

    always_comb begin
        if (init_base >= LIM_X) begin
            init_word = '0;
        end else if ((LIM_X - init_base) >= (PA_W + 1)'(WORD_BITS)) begin
            init_word = ONES;
        end else begin
            init_word = ~(ONES << LIM_X[WORD_SHIFT-1:0]);
        end
    end

    // marking mask for the current word
    logic [WORD_BITS-1:0]  mark_mask;

    always_comb begin
        mark_mask = ONES;
        if (r_widx == r_start[PA_W-1:WORD_SHIFT]) begin
            mark_mask = mark_mask & (ONES << r_start[WORD_SHIFT-1:0]);
        end
        if (r_widx == r_mlast[PA_W-1:WORD_SHIFT]) begin
            mark_mask = mark_mask &
                (ONES >> (WORD_SHIFT'(WORD_BITS - 1) - r_mlast[WORD_SHIFT-1:0]));
        end
    end

    // found-run setup shared by the word and chunk paths
    logic [PA_W-1:0]       hit_start;
    logic [PA_W-1:0]       hit_last;
    logic [AF_W-1:0]       addr_full;

    assign hit_start = (r_state == ST_CHUNK) ? cs_start : cand_eff;
    assign hit_last  = PA_W'(CNT_W'(hit_start) + CNT_W'(r_pages) - 1'b1);
    assign addr_full = AF_W'(r_start) << PAGE_SHIFT;

    always_comb begin
        n_state   = r_state;
        n_region  = r_region;
        n_pages   = r_pages;
        n_run     = r_run;
        n_cand    = r_cand;
        n_widx    = r_widx;
        n_chunk   = r_chunk;
        n_word    = r_word;
        n_start   = r_start;
        n_mlast   = r_mlast;
        n_found   = r_found;
        n_ovalid  = r_ovalid && !i_m_tready;
        n_ogrant  = r_ogrant;
        n_oaddr   = r_oaddr;
        ram_we    = 1'b0;
        ram_waddr = r_widx;
        ram_wdata = init_word;
        ram_re    = 1'b0;
        ram_raddr = r_widx;

        case (r_state)
            ST_INIT: begin
                ram_we = 1'b1;
                if (r_widx == LAST_W) begin
                    n_state = ST_IDLE;
                end else begin
                    n_widx = r_widx + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    n_region = i_s_tuser;
                    n_pages  = size_up[SIZE_W:PAGE_SHIFT];
                    n_run    = '0;
                    n_cand   = '0;
                    n_widx   = lo_w;
                    n_found  = 1'b0;
                    if (reg_empty) begin
                        n_state = ST_RESP;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = lo_w;
                        n_state   = ST_LATCH;
                    end
                end
            end
            ST_RD: begin
                ram_re  = 1'b1;
                n_state = ST_LATCH;
            end
            ST_LATCH: begin
                if (all_free && (pages_zero || fits)) begin
                    n_start = hit_start;
                    n_mlast = hit_last;
                    n_found = 1'b1;
                    n_widx  = hit_start[PA_W-1:WORD_SHIFT];
                    n_state = pages_zero ? ST_RESP : ST_MRD;
                end else if (all_used || all_free) begin
                    n_run  = all_used ? '0 : r_run + CNT_W'(WORD_BITS);
                    n_cand = cand_eff;
                    if (word_last) begin
                        n_state = ST_RESP;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_widx + 1'b1;
                        n_widx    = r_widx + 1'b1;
                    end
                end else begin
                    n_word  = eff_word;
                    n_chunk = '0;
                    n_state = ST_CHUNK;
                end
            end
            ST_CHUNK: begin
                n_run  = cs_run;
                n_cand = cs_cand;
                if (cs_hit) begin
                    n_start = hit_start;
                    n_mlast = hit_last;
                    n_found = 1'b1;
                    n_widx  = hit_start[PA_W-1:WORD_SHIFT];
                    n_state = pages_zero ? ST_RESP : ST_MRD;
                end else if (r_chunk == '1) begin
                    if (word_last) begin
                        n_state = ST_RESP;
                    end else begin
                        n_widx  = r_widx + 1'b1;
                        n_state = ST_RD;
                    end
                end else begin
                    n_chunk = r_chunk + 1'b1;
                end
            end
            ST_MRD: begin
                ram_re  = 1'b1;
                n_state = ST_MWR;
            end
            ST_MWR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | mark_mask;
                if (r_widx == r_mlast[PA_W-1:WORD_SHIFT]) begin
                    n_state = ST_RESP;
                end else begin
                    n_widx  = r_widx + 1'b1;
                    n_state = ST_MRD;
                end
            end
            ST_RESP: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_ogrant = r_found;
                    n_oaddr  = r_found ? addr_full[ADDR_W-1:0] : '0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
                n_widx  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_widx   <= '0;
            r_ovalid <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_widx   <= n_widx;
            r_ovalid <= n_ovalid;
            r_found  <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_region <= n_region;
        r_pages  <= n_pages;
        r_run    <= n_run;
        r_cand   <= n_cand;
        r_chunk  <= n_chunk;
        r_word   <= n_word;
        r_start  <= n_start;
        r_mlast  <= n_mlast;
        r_ogrant <= n_ogrant;
        r_oaddr  <= n_oaddr;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_ogrant;
    assign o_m_tdata  = OUT_DATA_W'(r_oaddr);

    a_no_req_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INIT) |-> !o_s_tready)
        else $error("request taken during clearing pass");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("failed response carries an address");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state == ST_LATCH || r_state == ST_RESP))
        else $error("bad state after request");

    a_mark_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MWR) |-> (r_widx >= r_start[PA_W-1:WORD_SHIFT] &&
                                 r_widx <= r_mlast[PA_W-1:WORD_SHIFT]))
        else $error("mark write outside granted run");

endmodule
